FILE: rtl/psfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Per-source flood detector package
// Shared beat types, register indexes and the sequencer's control store.
// ----------------------------------------------------------------------------
package psfd_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [4:0]  EntriesReset   = 5'd3;
  localparam logic [15:0] ThresholdReset = 16'd4;
  localparam logic [15:0] RateReset      = 16'd3;
  localparam logic        WarnReset      = 1'b0;

  typedef struct packed {
    logic [31:0] sender_key;
    logic [2:0]  msg_kind;
    logic [31:0] now_seconds;
  } item_t;

  typedef struct packed {
    logic flood_detected;
    logic first_detection;
    logic new_entry;
  } result_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ENTRIES   = 2'd0,
    REG_THRESHOLD = 2'd1,
    REG_RATE      = 2'd2,
    REG_WARN      = 2'd3
  } cfg_reg_e;

  // Sequencer steps; the step counter holds one of these.
  typedef enum logic [3:0] {
    ST_IDLE    = 4'd0,
    ST_CHK     = 4'd1,
    ST_RD      = 4'd2,
    ST_CMP     = 4'd3,
    ST_NXT     = 4'd4,
    ST_PINC    = 4'd5,
    ST_MOD     = 4'd6,
    ST_NEW     = 4'd7,
    ST_LATCH   = 4'd8,
    ST_MUL     = 4'd9,
    ST_JUDGE   = 4'd10,
    ST_RESTART = 4'd11,
    ST_FLOOD   = 4'd12,
    ST_WB      = 4'd13,
    ST_FIN     = 4'd14
  } step_e;

  typedef enum logic [3:0] {
    A_NONE       = 4'd0,
    A_LOAD       = 4'd1,
    A_READ       = 4'd2,
    A_NEXT       = 4'd3,
    A_PTR_INC    = 4'd4,
    A_MOD_REDUCE = 4'd5,
    A_NEW        = 4'd6,
    A_LATCH      = 4'd7,
    A_MUL        = 4'd8,
    A_RESTART    = 4'd9,
    A_FLOOD      = 4'd10,
    A_WRITE      = 4'd11,
    A_EMIT       = 4'd12
  } act_e;

  typedef enum logic [3:0] {
    C_NEVER     = 4'd0,
    C_ALWAYS    = 4'd1,
    C_NOT_START = 4'd2,
    C_NO_USERS  = 4'd3,
    C_HIT       = 4'd4,
    C_NOT_LAST  = 4'd5,
    C_MOD_GE    = 4'd6,
    C_LE_THR    = 4'd7,
    C_FLOOD     = 4'd8
  } cond_e;

  // One control word: the action for this step, a jump condition with its
  // target, and the step that follows when the jump is not taken.
  typedef struct packed {
    act_e  act;
    cond_e cond;
    step_e target;
    step_e seq;
  } ucode_t;

  function automatic ucode_t ucode_rom(step_e step);
    ucode_t w;
    unique case (step)
      ST_IDLE:    w = '{A_LOAD,       C_NOT_START, ST_IDLE,  ST_CHK};
      ST_CHK:     w = '{A_NONE,       C_NO_USERS,  ST_FIN,   ST_RD};
      ST_RD:      w = '{A_READ,       C_NEVER,     ST_CMP,   ST_CMP};
      ST_CMP:     w = '{A_NONE,       C_HIT,       ST_LATCH, ST_NXT};
      ST_NXT:     w = '{A_NEXT,       C_NOT_LAST,  ST_RD,    ST_PINC};
      ST_PINC:    w = '{A_PTR_INC,    C_NEVER,     ST_MOD,   ST_MOD};
      ST_MOD:     w = '{A_MOD_REDUCE, C_MOD_GE,    ST_MOD,   ST_NEW};
      ST_NEW:     w = '{A_NEW,        C_NEVER,     ST_WB,    ST_WB};
      ST_LATCH:   w = '{A_LATCH,      C_NEVER,     ST_MUL,   ST_MUL};
      ST_MUL:     w = '{A_MUL,        C_LE_THR,    ST_WB,    ST_JUDGE};
      ST_JUDGE:   w = '{A_NONE,       C_FLOOD,     ST_FLOOD, ST_RESTART};
      ST_RESTART: w = '{A_RESTART,    C_ALWAYS,    ST_WB,    ST_WB};
      ST_FLOOD:   w = '{A_FLOOD,      C_NEVER,     ST_WB,    ST_WB};
      ST_WB:      w = '{A_WRITE,      C_NEVER,     ST_FIN,   ST_FIN};
      ST_FIN:     w = '{A_EMIT,       C_ALWAYS,    ST_IDLE,  ST_IDLE};
      default:    w = '{A_NONE,       C_ALWAYS,    ST_IDLE,  ST_IDLE};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/psfd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port; read data is registered and holds
// between reads.
// ----------------------------------------------------------------------------
module psfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                              wdata_i,
  input  wire logic                                          re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output      logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: rtl/per_source_flood_detector_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Per-source flood detector
// Tracks message counts per sender and kind and flags senders whose message
// rate runs above a programmable limit.
// ----------------------------------------------------------------------------
// A message beat is taken when start is high while busy is low; busy then
// stays high until the single result beat has been shown on result_o for one
// cycle with result_valid_o high. The receiver cannot stall, so result_o must
// be sampled in that cycle. With detection disabled (entry count zero) the
// sequencer goes from its check step straight to the result. Otherwise the
// table is searched one entry at a time through the slot memory's registered
// read port, with a read, a compare and a next step per entry. A miss then
// steps the replacement pointer and repeats its reduction step each time the
// pointer steps past the last tracked slot, which happens once on an ordinary
// wrap and several times after the entry count has been lowered.
// Configuration writes are accepted while busy and start are both low;
// writing the entry count empties the table at once.
// ----------------------------------------------------------------------------
module per_source_flood_detector_unit
  import psfd_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned KEY_WIDTH   = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output      logic                busy,
  input  wire item_t               item_i,
  output      logic                result_valid_o,
  output      result_t             result_o,
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned RamW = KEY_WIDTH + 3 + 32 + 32 + 1;

  // Configuration registers.
  logic [4:0]  entries_q;
  logic [15:0] thr_q;
  logic [15:0] rate_q;
  logic        warn_q;

  // Sequencer.
  step_e  step_q, step_d;
  ucode_t uc;
  logic   taken;

  // Datapath registers.
  logic [KEY_WIDTH-1:0]   key_q;
  logic [2:0]             kind_q;
  logic [31:0]            now_q;
  logic [AW-1:0]          idx_q;
  logic [AW-1:0]          ptr_q;
  logic [CW-1:0]          mod_q;
  logic [31:0]            cnt_q;
  logic [31:0]            start_q;
  logic                   flag_q;
  logic [31:0]            elapsed_q;
  logic [48:0]            prod_q;
  result_t                res_q;
  logic [TABLE_DEPTH-1:0] valid_q;

  logic [CW-1:0]          users;
  logic                   hit;
  logic                   cfg_we;

  // Slot memory: key, kind, count, window start and flood flag per entry.
  logic                 ram_we;
  logic                 ram_re;
  logic [RamW-1:0]      ram_wdata;
  logic [RamW-1:0]      ram_rdata;
  logic [KEY_WIDTH-1:0] rd_key;
  logic [2:0]           rd_kind;
  logic [31:0]          rd_count;
  logic [31:0]          rd_start;
  logic                 rd_flag;

  psfd_ram #(
    .WIDTH (RamW),
    .DEPTH (TABLE_DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign {rd_key, rd_kind, rd_count, rd_start, rd_flag} = ram_rdata;
  assign ram_wdata = {key_q, kind_q, cnt_q, start_q, flag_q};

  // Entry counts above the table size are clamped to the table size.
  always_comb begin
    if (32'(entries_q) > 32'(TABLE_DEPTH)) begin
      users = CW'(TABLE_DEPTH);
    end else begin
      users = CW'(entries_q);
    end
  end

  // A slot matches only if it holds a live entry; its key and kind are
  // meaningless otherwise.
  assign hit = valid_q[idx_q] && (rd_key == key_q) && (rd_kind == kind_q);

  // Next step: the control word's condition picks the jump target or the
  // fall-through step.
  always_comb begin
    uc = ucode_rom(step_q);
    unique case (uc.cond)
      C_NEVER:     taken = 1'b0;
      C_ALWAYS:    taken = 1'b1;
      C_NOT_START: taken = !start;
      C_NO_USERS:  taken = (users == '0);
      C_HIT:       taken = hit;
      C_NOT_LAST:  taken = ((CW'(idx_q) + CW'(1)) != users);
      C_MOD_GE:    taken = (mod_q >= users);
      C_LE_THR:    taken = (cnt_q <= {16'd0, thr_q});
      C_FLOOD:     taken = ({17'd0, cnt_q} >= prod_q);
      default:     taken = 1'b0;
    endcase
    step_d = taken ? uc.target : uc.seq;
  end

  // Control outputs decoded from the current control word. A register write
  // is held off while a message beat is being taken, so the message always
  // sees the settings from before the write.
  always_comb begin
    ram_re         = (uc.act == A_READ);
    ram_we         = (uc.act == A_WRITE);
    result_valid_o = (uc.act == A_EMIT);
    busy           = (step_q != ST_IDLE);
    cfg_ready_o    = (step_q == ST_IDLE) && !start;
  end

  assign cfg_we   = cfg_valid_i && cfg_ready_o;
  assign result_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= ST_IDLE;
      entries_q <= EntriesReset;
      thr_q     <= ThresholdReset;
      rate_q    <= RateReset;
      warn_q    <= WarnReset;
      valid_q   <= '0;
      ptr_q     <= '0;
    end else begin
      step_q <= step_d;
      if (cfg_we) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_ENTRIES: begin
            entries_q <= cfg_data_i[4:0];
            valid_q   <= '0;
          end
          REG_THRESHOLD: thr_q  <= cfg_data_i;
          REG_RATE:      rate_q <= cfg_data_i;
          REG_WARN:      warn_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (uc.act == A_WRITE) begin
        valid_q[idx_q] <= 1'b1;
      end
      if (uc.act == A_NEW) begin
        ptr_q <= mod_q[AW-1:0];
      end
    end
  end

  // Payload side of the datapath; no reset needed.
  always_ff @(posedge clk_i) begin
    unique case (uc.act)
      A_LOAD: begin
        key_q  <= KEY_WIDTH'(item_i.sender_key);
        kind_q <= item_i.msg_kind;
        now_q  <= item_i.now_seconds;
        idx_q  <= '0;
        res_q  <= '0;
      end
      A_NEXT: idx_q <= idx_q + 1'b1;
      A_PTR_INC: mod_q <= CW'(ptr_q) + CW'(1);
      A_MOD_REDUCE: begin
        if (mod_q >= users) begin
          mod_q <= mod_q - users;
        end
      end
      A_NEW: begin
        idx_q           <= mod_q[AW-1:0];
        cnt_q           <= 32'd1;
        start_q         <= now_q;
        flag_q          <= 1'b0;
        res_q.new_entry <= 1'b1;
      end
      A_LATCH: begin
        cnt_q     <= (rd_count == '1) ? rd_count : rd_count + 32'd1;
        start_q   <= rd_start;
        flag_q    <= rd_flag;
        elapsed_q <= now_q - rd_start;
      end
      // floor(count / elapsed) > limit is the same as
      // count >= (limit + 1) * elapsed; a zero elapsed time always passes.
      A_MUL: prod_q <= 49'({1'b0, rate_q} + 17'd1) * 49'(elapsed_q);
      A_RESTART: begin
        cnt_q   <= 32'd1;
        start_q <= now_q;
        flag_q  <= 1'b0;
      end
      A_FLOOD: begin
        res_q.flood_detected <= 1'b1;
        if (!flag_q) begin
          flag_q                <= 1'b1;
          res_q.first_detection <= warn_q;
        end
      end
      default: ;
    endcase
  end

  // A replaced slot and a flood verdict never come from the same message.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !(result_o.new_entry && result_o.flood_detected))
    else $error("new entry reported together with a flood verdict");

  // A first detection is always part of a flood.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.first_detection |-> result_o.flood_detected)
    else $error("first detection without flood");

  // The pointer reduction has finished before a slot is replaced.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == ST_NEW) |-> (mod_q < users))
    else $error("replacement slot out of range");

  // An accepted message always starts the sequencer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted message did not start the sequencer");

  // Slot memory writes only happen after a search or a replacement.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ($past(step_q) == ST_NEW || $past(step_q) == ST_MUL ||
                $past(step_q) == ST_RESTART || $past(step_q) == ST_FLOOD))
    else $error("slot write outside of an update");

endmodule
`default_nettype wire

FILE: bench/tb_per_source_flood_detector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-source flood detector testbench
// Drives message beats through the start/busy port and checks every verdict
// beat against a cycle-free predictor of the sender table. Register settings
// change between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_per_source_flood_detector_unit;
  import psfd_pkg::*;

  localparam int unsigned TableDepth    = 16;
  // The watchdog runs on cycles in which no beat of any kind is taken. The
  // limit is many times over the slowest message and the longest sender gap.
  localparam int unsigned WatchdogLimit = 2000;
  // Cycles allowed after the last verdict before the run closes. This is a
  // little above the worst-case message latency.
  localparam int unsigned SettleCycles  = 64;

  // --------------------------------------------------------------------------
  // Predictor and verdict checker. It keeps its own copy of the sender table
  // and the registers, and queues one expected verdict per accepted message.
  // --------------------------------------------------------------------------
  class flood_scoreboard;
    bit          slot_used    [TableDepth];
    bit   [31:0] slot_sender  [TableDepth];
    bit   [2:0]  slot_type    [TableDepth];
    bit   [31:0] slot_hits    [TableDepth];
    bit   [31:0] slot_since   [TableDepth];
    bit          slot_flooding[TableDepth];
    int unsigned last_slot;
    bit   [4:0]  tracked;
    bit   [15:0] hit_threshold;
    bit   [15:0] max_rate;
    bit          warn_on;
    result_t     pending_verdicts[$];
    int unsigned errors;

    function new();
      empty_table();
      last_slot     = 0;
      tracked       = EntriesReset;
      hit_threshold = ThresholdReset;
      max_rate      = RateReset;
      warn_on       = WarnReset;
      errors        = 0;
    endfunction

    function void empty_table();
      for (int i = 0; i < TableDepth; i++) begin
        slot_used[i]     = 1'b0;
        slot_hits[i]     = '0;
        slot_flooding[i] = 1'b0;
      end
    endfunction

    function void write_register(cfg_reg_e idx, logic [15:0] data);
      case (idx)
        REG_ENTRIES: begin
          tracked = data[4:0];
          empty_table();
        end
        REG_THRESHOLD: hit_threshold = data;
        REG_RATE:      max_rate = data;
        REG_WARN:      warn_on = data[0];
        default: ;
      endcase
    endfunction

    // Works out the verdict for one accepted message and updates the table.
    function void note_message(item_t msg);
      result_t     verdict;
      int unsigned users;
      int unsigned hit;
      bit          found;
      bit   [31:0] elapsed;
      verdict = '0;
      hit     = 0;
      found   = 1'b0;
      // Entry counts above the table size track the whole table.
      users = (tracked > TableDepth) ? TableDepth : tracked;
      if (users != 0) begin
        for (int i = 0; i < users; i++) begin
          if (!found && slot_used[i] && slot_sender[i] == msg.sender_key &&
              slot_type[i] == msg.msg_kind) begin
            hit   = i;
            found = 1'b1;
          end
        end
        if (!found) begin
          // The pointer survives a shrink of the entry count, so it is
          // reduced on use rather than on the register write.
          last_slot                = (last_slot + 1) % users;
          slot_used[last_slot]     = 1'b1;
          slot_sender[last_slot]   = msg.sender_key;
          slot_type[last_slot]     = msg.msg_kind;
          slot_hits[last_slot]     = 32'd1;
          slot_since[last_slot]    = msg.now_seconds;
          slot_flooding[last_slot] = 1'b0;
          verdict.new_entry        = 1'b1;
        end else begin
          if (slot_hits[hit] != '1) slot_hits[hit]++;
          if (slot_hits[hit] > {16'd0, hit_threshold}) begin
            // Wraps when time runs backwards, which makes the rate tiny.
            elapsed = msg.now_seconds - slot_since[hit];
            if (elapsed == 0 || slot_hits[hit] / elapsed > {16'd0, max_rate}) begin
              if (!slot_flooding[hit]) begin
                slot_flooding[hit]      = 1'b1;
                verdict.first_detection = warn_on;
              end
              verdict.flood_detected = 1'b1;
            end else begin
              slot_flooding[hit] = 1'b0;
              slot_hits[hit]     = 32'd1;
              slot_since[hit]    = msg.now_seconds;
            end
          end
        end
      end
      pending_verdicts.push_back(verdict);
    endfunction

    function void check_verdict(result_t got);
      result_t want;
      if (pending_verdicts.size() == 0) begin
        $error("verdict beat with no message outstanding: %b", got);
        errors++;
      end else begin
        want = pending_verdicts.pop_front();
        if (got.flood_detected !== want.flood_detected) begin
          $error("flood_detected: expected %0b, got %0b",
                 want.flood_detected, got.flood_detected);
          errors++;
        end
        if (got.first_detection !== want.first_detection) begin
          $error("first_detection: expected %0b, got %0b",
                 want.first_detection, got.first_detection);
          errors++;
        end
        if (got.new_entry !== want.new_entry) begin
          $error("new_entry: expected %0b, got %0b", want.new_entry, got.new_entry);
          errors++;
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals around the block. Every input has a known value from time zero.
  // --------------------------------------------------------------------------
  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                start     = 1'b0;
  logic                busy;
  item_t               message   = '0;
  logic                verdict_valid;
  result_t             verdict;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  flood_scoreboard sb = new();

  // Simulated wall clock in seconds and the sender keys of the current phase.
  logic [31:0] clock_s = 32'd1000;
  logic [31:0] key_pool[8];
  int unsigned burst_left = 0;
  int unsigned quiet_cycles = 0;

  always #2 clk = ~clk;

  per_source_flood_detector_unit dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (start),
    .busy           (busy),
    .item_i         (message),
    .result_valid_o (verdict_valid),
    .result_o       (verdict),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Monitor. All three channels are sampled at the rising edge, where the
  // inputs have been stable since the falling edge. A verdict beat belongs to
  // an older message, so it is checked before a new message is noted. The
  // watchdog closes the run after too many cycles without any beat.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      quiet_cycles++;
      if (verdict_valid) begin
        sb.check_verdict(verdict);
        quiet_cycles = 0;
      end
      if (start && !busy) begin
        sb.note_message(message);
        quiet_cycles = 0;
      end
      if (cfg_valid && cfg_ready) begin
        sb.write_register(cfg_reg_e'(cfg_index), cfg_data);
        quiet_cycles = 0;
      end
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers. Inputs change only at the falling edge.
  // --------------------------------------------------------------------------

  // Presents one message beat and returns once it has been taken. Start is
  // left high so that a burst runs back to back.
  task automatic send_message(item_t msg);
    @(negedge clk);
    start   = 1'b1;
    message = msg;
    do @(posedge clk); while (busy);
  endtask

  // The sender works in bursts; between bursts start drops for a random
  // number of cycles, so the next beat lands at any point of the search.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      gap        = $urandom_range(1, 70);
      burst_left = ($urandom_range(5) == 0) ? 40 : $urandom_range(0, 8);
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Waits until every message has its verdict; the block is then idle.
  task automatic drain_verdicts();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending_verdicts.size() != 0) @(negedge clk);
  endtask

  task automatic drive_register(cfg_reg_e idx, logic [15:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Most messages come from the phase's small set of senders with the two
  // common kinds, so that entries get hit often enough to reach the rate
  // check. The rest are fresh senders and rarer kinds. Time mostly stands
  // still or creeps forward, with rare long jumps and rare steps backwards.
  function automatic item_t random_message(int unsigned pool);
    item_t       msg;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 85) msg.sender_key = key_pool[3'($urandom_range(pool - 1))];
    else           msg.sender_key = $urandom();
    roll = $urandom_range(99);
    if (roll < 85) msg.msg_kind = 3'($urandom_range(1));
    else           msg.msg_kind = 3'($urandom_range(7));
    roll = $urandom_range(99);
    if (roll >= 97)      clock_s = clock_s - $urandom_range(1, 50);
    else if (roll >= 93) clock_s = clock_s + $urandom();
    else if (roll >= 80) clock_s = clock_s + $urandom_range(2, 12);
    else if (roll >= 45) clock_s = clock_s + 1;
    msg.now_seconds = clock_s;
    return msg;
  endfunction

  // One phase: wait for idle, program all four registers (with random bits above
  // the entry count's and the warn flag's widths), pick a sender set, then send random traffic.
  task automatic run_phase(logic [4:0] entries, logic [15:0] threshold,
                           logic [15:0] rate, logic warn,
                           int unsigned count, int unsigned pool);
    logic [15:0] noise;
    drain_verdicts();
    noise = 16'($urandom());
    drive_register(REG_ENTRIES, {noise[15:5], entries});
    drive_register(REG_THRESHOLD, threshold);
    drive_register(REG_RATE, rate);
    noise = 16'($urandom());
    drive_register(REG_WARN, {noise[15:1], warn});
    for (int i = 0; i < 8; i++) begin
      key_pool[i] = ($urandom_range(7) == 0) ? 32'd0 : $urandom();
    end
    repeat (count) begin
      send_message(random_message(pool));
      pace_sender();
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed part under the reset settings: three entries, threshold 4,
    // rate 3, warnings off. Key zero floods on a burst within one second and
    // stays flagged; the all-ones key with undefined kinds gets its own
    // entries, and one of them sees time run backwards, which restarts it.
    // The rest covers the remaining kinds and the ends of the time range.
    repeat (6) send_message(item_t'{32'h0000_0000, 3'd0, 32'd100});
    send_message(item_t'{32'h0000_0000, 3'd0, 32'd101});
    send_message(item_t'{32'hFFFF_FFFF, 3'd7, 32'd101});
    send_message(item_t'{32'hFFFF_FFFF, 3'd6, 32'd101});
    repeat (4) send_message(item_t'{32'hFFFF_FFFF, 3'd7, 32'd50});
    send_message(item_t'{32'h1234_5678, 3'd1, 32'hFFFF_FFFF});
    send_message(item_t'{32'h1234_5678, 3'd2, 32'hFFFF_FFFF});
    send_message(item_t'{32'h0000_0000, 3'd3, 32'hFFFF_FFFF});
    send_message(item_t'{32'h0000_0000, 3'd4, 32'd0});
    send_message(item_t'{32'h0000_0000, 3'd5, 32'd0});

    // Random phases. The full table first; then a single entry with a zero
    // threshold and zero rate, where almost any repeat floods. The sixteen
    // entry phase that follows leaves the pointer high, so the shrink to two
    // entries exercises the pointer wrap. An entry count above the table
    // size, and zero (detection off), are both covered. The wall clock is
    // set just below its top once so that it wraps mid-phase.
    clock_s = 32'd5000;
    run_phase(5'd16, 16'd2,     16'd1,     1'b1, 60, 8);
    run_phase(5'd1,  16'd0,     16'd0,     1'b1, 50, 2);
    run_phase(5'd5,  16'd3,     16'd2,     1'b0, 50, 4);
    run_phase(5'd0,  16'd1,     16'd1,     1'b1, 20, 4);
    clock_s = 32'hFFFF_FFF0;
    run_phase(5'd31, 16'hFFFF,  16'hFFFF,  1'b1, 30, 6);
    run_phase(5'd16, 16'd1,     16'd2,     1'b1, 40, 8);
    run_phase(5'd2,  16'd6,     16'hFFFF,  1'b1, 50, 3);
    run_phase(5'd7,  16'd1,     16'd5,     1'b1, 60, 5);
    run_phase(5'd3,  16'd4,     16'd3,     1'b0, 60, 4);

    drain_verdicts();
    repeat (SettleCycles) @(posedge clk);
    if (sb.errors == 0 && sb.pending_verdicts.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: per_source_flood_detector_unit.f
rtl/psfd_pkg.sv
rtl/psfd_ram.sv
rtl/per_source_flood_detector_unit.sv
bench/tb_per_source_flood_detector_unit.sv
